// ===== rtl/dms_pkg.sv =====
// Shared types, codes and helpers for the driving mode supervisor.
`default_nettype none
package dms_pkg;

	localparam int unsigned OPCODE_W       = 3;
	localparam int unsigned MODE_W         = 4;
	localparam int unsigned TICKS_W        = 8;
	localparam logic [TICKS_W-1:0] SELF_TEST_MIN_TICKS_RST = 8'd10;
	localparam logic [TICKS_W-1:0] TICKS_MAX               = 8'hFF;

	typedef enum logic [OPCODE_W-1:0] {
		OP_TICK    = 3'd0,
		OP_IGN_ON  = 3'd1,
		OP_IGN_OFF = 3'd2,
		OP_ENGAGE  = 3'd3,
		OP_DISENG  = 3'd4
	} opcode_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_OFF      = 4'd0,
		MODE_SELFTEST = 4'd1,
		MODE_STANDBY  = 4'd2,
		MODE_ACTIVE   = 4'd3,
		MODE_DEGRADED = 4'd4,
		MODE_SAFESTOP = 4'd5,
		MODE_MINRISK  = 4'd6,
		MODE_PULLOVER = 4'd7,
		MODE_FAULT    = 4'd8
	} mode_t;

	// One event as it sits in the input stage.
	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic                self_test_passed;
		logic                domain_valid;
		logic                critical_fault;
		logic                major_fault;
		logic                emergency_stop;
		logic                pullover_done;
	} evt_t;

	// Supervisor state carried between events.
	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [TICKS_W-1:0] ticks;
		logic               engage;
	} sup_state_t;

	function automatic logic is_safe_mode(input logic [MODE_W-1:0] m);
		return (m == MODE_OFF) || (m == MODE_SAFESTOP) || (m == MODE_FAULT);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/dms_if.sv =====
// Valid/ready channel interfaces for events and results.
`default_nettype none
interface dms_in_if;
	import dms_pkg::*;
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic                self_test_passed;
	logic                domain_valid;
	logic                critical_fault;
	logic                major_fault;
	logic                emergency_stop;
	logic                pullover_done;

	modport source (output valid, output opcode, output self_test_passed,
		output domain_valid, output critical_fault, output major_fault,
		output emergency_stop, output pullover_done, input ready);
	modport sink (input valid, input opcode, input self_test_passed,
		input domain_valid, input critical_fault, input major_fault,
		input emergency_stop, input pullover_done, output ready);
endinterface

interface dms_out_if;
	import dms_pkg::*;
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic              in_safe_mode;
	logic              engage_pending;

	modport source (output valid, output mode, output in_safe_mode,
		output engage_pending, input ready);
	modport sink (input valid, input mode, input in_safe_mode,
		input engage_pending, output ready);
endinterface
`default_nettype wire

// ===== rtl/driving_mode_supervisor_core.sv =====
// Top level of the driving mode supervisor: input stage, decode, result register.
//
//   Channel   Dir   Handshake       Beat payload
//   evt       in    valid/ready     opcode and six condition flags
//   res       out   valid/ready     mode, in_safe_mode, engage_pending
//   cfg       in    cfg_wr_en       self_test_min_ticks (8 bits)
//
// One beat is accepted per cycle unless the sink stalls the result; a taken
// beat passes from the input stage to the result register and is presented there.
// The input stage and the result register form a two-deep pipeline; the
// supervisor state is updated in the same cycle the result is registered.
// When the result is held by the sink, a full input stage holds its beat and
// takes a new one only as the stalled result leaves. Reset empties both stages,
// sets the mode to off and the minimum self-test length to ten ticks.
`default_nettype none
module driving_mode_supervisor_core
	import dms_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [TICKS_W-1:0] cfg_wr_data,
	dms_in_if.sink             evt,
	dms_out_if.source          res
);

	evt_t               evt_s1;
	logic               valid_s1;
	sup_state_t         state_q;
	sup_state_t         state_nxt;
	logic [TICKS_W-1:0] min_ticks_q;
	logic               valid_s2;
	logic [MODE_W-1:0]  mode_s2;
	logic               safe_s2;
	logic               engage_s2;
	logic               advance;

	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign evt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_ticks_q <= SELF_TEST_MIN_TICKS_RST;
		end else if (cfg_wr_en) begin
			min_ticks_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			evt_s1 <= '{opcode: evt.opcode, self_test_passed: evt.self_test_passed,
				domain_valid: evt.domain_valid, critical_fault: evt.critical_fault,
				major_fault: evt.major_fault, emergency_stop: evt.emergency_stop,
				pullover_done: evt.pullover_done};
		end
	end

	dms_next_state u_next (
		.evt       (evt_s1),
		.cur       (state_q),
		.min_ticks (min_ticks_q),
		.nxt       (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: MODE_OFF, ticks: '0, engage: 1'b0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode_s2   <= state_nxt.mode;
			safe_s2   <= is_safe_mode(state_nxt.mode);
			engage_s2 <= state_nxt.engage;
		end
	end

	assign res.valid          = valid_s2;
	assign res.mode           = mode_s2;
	assign res.in_safe_mode   = safe_s2;
	assign res.engage_pending = engage_s2;

endmodule
`default_nettype wire

// ===== rtl/dms_next_state.sv =====
// Next-state decode of the supervisor for one event.
`default_nettype none
module dms_next_state
	import dms_pkg::*;
(
	input  evt_t               evt,
	input  sup_state_t         cur,
	input  logic [TICKS_W-1:0] min_ticks,
	output sup_state_t         nxt
);

	logic [TICKS_W-1:0] ticks_inc;
	logic               crit_or_stop;
	logic               domain_lost;

	assign ticks_inc    = (cur.ticks == TICKS_MAX) ? cur.ticks : cur.ticks + 8'd1;
	assign crit_or_stop = evt.critical_fault | evt.emergency_stop;
	assign domain_lost  = ~evt.domain_valid | evt.major_fault;

	always_comb begin
		nxt = cur;
		case (opcode_t'(evt.opcode))
			OP_TICK: begin
				case (mode_t'(cur.mode))
					MODE_SELFTEST: begin
						nxt.ticks = ticks_inc;
						if (evt.critical_fault) begin
							nxt.mode = MODE_FAULT;
						end else if (ticks_inc >= min_ticks && evt.self_test_passed) begin
							nxt.mode = MODE_STANDBY;
						end
					end
					MODE_STANDBY: begin
						if (evt.critical_fault) begin
							nxt.mode = MODE_FAULT;
						end else if (cur.engage && evt.domain_valid && !evt.major_fault) begin
							nxt.mode   = MODE_ACTIVE;
							nxt.engage = 1'b0;
						end else if (cur.engage && evt.major_fault) begin
							nxt.mode = MODE_DEGRADED;
						end
					end
					MODE_ACTIVE: begin
						if (crit_or_stop) begin
							nxt.mode = MODE_SAFESTOP;
						end else if (domain_lost) begin
							nxt.mode = MODE_MINRISK;
						end
					end
					MODE_DEGRADED: begin
						if (crit_or_stop) begin
							nxt.mode = MODE_SAFESTOP;
						end else if (domain_lost) begin
							nxt.mode = MODE_MINRISK;
						end else if (cur.engage) begin
							nxt.mode = MODE_ACTIVE;
						end
					end
					MODE_MINRISK: begin
						if (crit_or_stop || evt.pullover_done) begin
							nxt.mode = MODE_SAFESTOP;
						end
					end
					MODE_PULLOVER: begin
						if (evt.pullover_done) begin
							nxt.mode = MODE_SAFESTOP;
						end
					end
					default: begin
						nxt.mode = cur.mode;
					end
				endcase
			end
			OP_IGN_ON: begin
				if (cur.mode == MODE_OFF) begin
					nxt.mode  = MODE_SELFTEST;
					nxt.ticks = '0;
				end
			end
			OP_IGN_OFF: begin
				nxt.mode   = MODE_OFF;
				nxt.engage = 1'b0;
			end
			OP_ENGAGE: begin
				if (cur.mode == MODE_STANDBY || cur.mode == MODE_DEGRADED) begin
					nxt.engage = 1'b1;
				end
			end
			OP_DISENG: begin
				if (cur.mode == MODE_ACTIVE || cur.mode == MODE_DEGRADED) begin
					nxt.mode   = MODE_STANDBY;
					nxt.engage = 1'b0;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/dms_checker.sv =====
// Port-level checks on the supervisor, bound to the top level.
`default_nettype none
module dms_checker
	import dms_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input logic [MODE_W-1:0] res_mode,
	input logic              res_safe,
	input logic              res_engage
);

	// A stalled result beat must not change.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_mode)
			&& $stable(res_safe) && $stable(res_engage))
		else $error("result beat changed while stalled");

	// The safe flag follows the reported mode.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_safe == (res_mode == MODE_OFF || res_mode == MODE_SAFESTOP
			|| res_mode == MODE_FAULT))
		else $error("safe flag disagrees with mode");

	// Pull-over and the unused codes are never reached from reset.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_mode != MODE_PULLOVER && res_mode <= MODE_FAULT)
		else $error("unreachable mode reported");

	// Off is only entered through ignition off, which drops a pending engage.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_mode == MODE_OFF |-> !res_engage)
		else $error("engage pending while off");

endmodule

bind driving_mode_supervisor_core dms_checker u_dms_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_mode   (res.mode),
	.res_safe   (res.in_safe_mode),
	.res_engage (res.engage_pending)
);
`default_nettype wire
